// File: hdl/hms_pkg.sv
// Shared types and constants for the hh:mm:ss clock block.
// No dependencies; imported by hms_cnt_cell and the top level.
`default_nettype none

package hms_pkg;

  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_RX    = 2'd1,
    REQ_KEY_A = 2'd2,
    REQ_KEY_B = 2'd3
  } req_t;

  localparam logic [3:0] CMD_LED_NIB = 4'hA;
  localparam logic [7:0] CMD_READ    = 8'hB0;

  localparam logic [7:0] TPS_RESET = 8'd20;
  localparam logic [7:0] LED_RESET = 8'hFF;
  localparam logic [5:0] SEC_LIMIT = 6'd60;
  localparam logic [5:0] MIN_LIMIT = 6'd60;
  localparam logic [6:0] HR_LIMIT  = 7'd100;

  localparam int unsigned LED_KEY_A_BIT = 7;
  localparam int unsigned LED_KEY_B_BIT = 6;

  // Packed BCD of a value below 100: tens by reciprocal multiply (205/2048).
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [7:0]  tens_x10;
    logic [3:0]  units;
    prod     = 15'(v) * 15'd205;
    tens     = prod[14:11];
    tens_x10 = {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0};
    units    = 4'(8'(v) - tens_x10);
    return {tens, units};
  endfunction

endpackage

`default_nettype wire

// File: hdl/hms_cnt_cell.sv
// One counter cell of the time chain: counts on carry in, wraps at a limit.
// Depends on hms_pkg.
`default_nettype none

module hms_cnt_cell
  import hms_pkg::*;
#(
  parameter int unsigned W = 8
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         inc_i,
  input  wire logic [W-1:0] limit_i,
  output logic      [W-1:0] cnt_o,
  output logic              carry_o
);

  logic [W-1:0] cnt_r;
  logic [W-1:0] cnt_nxt;
  logic [W-1:0] cnt_inc;
  logic         wrap;

  assign cnt_inc = cnt_r + W'(1);
  assign wrap    = (cnt_inc == limit_i);
  assign carry_o = inc_i & wrap;
  assign cnt_o   = cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (inc_i) begin
      cnt_nxt = wrap ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/hms_clock_with_serial_commands.sv
// Top level of the hh:mm:ss clock with serial commands and LED keys.
// Depends on hms_pkg and hms_cnt_cell (prescaler, seconds, minutes, hours).
//
//   channel  | direction | tdata                      | tuser        | tlast
//   ---------+-----------+----------------------------+--------------+-------------
//   in_      | slave     | [7:0] rx_byte              | [1:0] type   | -
//   out_     | master    | [7:0] tx_byte, [15:8] led  | [0] has_byte | last result
//   cfg_     | write     | [7:0] ticks_per_second     | -            | -
//
// A read command (0xB0) gives three result words, and input is held off
// until the last of them is loaded. The four counter cells carry in the same cycle,
// so ticks can arrive every cycle while input is not held off.
// Reset (rst_n low, synchronous) clears the time, sets LEDs off and the
// prescaler limit to 20. The result register lets a new word in while the
// previous one is taken in the same cycle; a stall on out_tready holds input.
`default_nettype none

module hms_clock_with_serial_commands
  import hms_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  wire logic [1:0]  in_tuser,   // [1:0] req_type
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [15:0] out_tdata,  // [7:0] tx_byte, [15:8] led_pattern
  output logic      [0:0]  out_tuser,  // [0] has_byte
  output logic             out_tlast,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_wdata   // [7:0] ticks_per_second
);

  // Configuration and LED state
  logic [7:0] tps_r;
  logic [7:0] led_r;
  logic [7:0] led_nxt;

  // Counter chain
  logic [7:0] tick_cnt;
  logic [5:0] sec_cnt;
  logic [5:0] min_cnt;
  logic [6:0] hr_cnt;
  logic       tick_carry;
  logic       sec_carry;
  logic       min_carry;
  logic       hr_carry;

  // Result register and pending read-out words
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r,  out_byte_nxt;
  logic [7:0] out_led_r,   out_led_nxt;
  logic       out_has_r,   out_has_nxt;
  logic       out_last_r,  out_last_nxt;
  logic [1:0] pend_cnt_r,  pend_cnt_nxt;
  logic [7:0] pend0_r,     pend0_nxt;
  logic [7:0] pend1_r,     pend1_nxt;

  logic       accept;
  logic       out_pop;
  logic       is_tick;
  logic       is_read;
  req_t       req;

  assign req       = req_t'(in_tuser);
  assign out_pop   = out_valid_r & out_tready;
  assign in_tready = (pend_cnt_r == 2'd0) & (~out_valid_r | out_tready);
  assign accept    = in_tvalid & in_tready;
  assign is_tick   = accept & (req == REQ_TICK);
  assign is_read   = (req == REQ_RX) & (in_tdata == CMD_READ);

  // Ripple the carry down the chain: prescaler -> seconds -> minutes -> hours
  hms_cnt_cell #(.W(8)) u_presc (
    .clk(clk), .rst_n(rst_n), .inc_i(is_tick), .limit_i(tps_r),
    .cnt_o(tick_cnt), .carry_o(tick_carry)
  );

  hms_cnt_cell #(.W(6)) u_sec (
    .clk(clk), .rst_n(rst_n), .inc_i(tick_carry), .limit_i(SEC_LIMIT),
    .cnt_o(sec_cnt), .carry_o(sec_carry)
  );

  hms_cnt_cell #(.W(6)) u_min (
    .clk(clk), .rst_n(rst_n), .inc_i(sec_carry), .limit_i(MIN_LIMIT),
    .cnt_o(min_cnt), .carry_o(min_carry)
  );

  hms_cnt_cell #(.W(7)) u_hr (
    .clk(clk), .rst_n(rst_n), .inc_i(min_carry), .limit_i(HR_LIMIT),
    .cnt_o(hr_cnt), .carry_o(hr_carry)
  );

  // LED update: serial 0xA_ sets low nibble to inverted data, keys toggle bits
  always_comb begin
    led_nxt = led_r;
    if (accept) begin
      case (req)
        REQ_RX: begin
          if (in_tdata[7:4] == CMD_LED_NIB) begin
            led_nxt = {led_r[7:4], ~in_tdata[3:0]};
          end
        end
        REQ_KEY_A: led_nxt[LED_KEY_A_BIT] = ~led_r[LED_KEY_A_BIT];
        REQ_KEY_B: led_nxt[LED_KEY_B_BIT] = ~led_r[LED_KEY_B_BIT];
        default:   led_nxt = led_r;
      endcase
    end
  end

  // Result register: load a fresh word on accept, else drain pending words
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_led_nxt   = out_led_r;
    out_has_nxt   = out_has_r;
    out_last_nxt  = out_last_r;
    pend_cnt_nxt  = pend_cnt_r;
    pend0_nxt     = pend0_r;
    pend1_nxt     = pend1_r;

    if (out_pop) begin
      out_valid_nxt = 1'b0;
    end

    if (accept) begin
      out_valid_nxt = 1'b1;
      out_led_nxt   = led_nxt;
      if (is_read) begin
        // hours now, minutes and seconds wait in the pending slots
        out_byte_nxt = to_bcd(hr_cnt);
        out_has_nxt  = 1'b1;
        out_last_nxt = 1'b0;
        pend0_nxt    = to_bcd({1'b0, min_cnt});
        pend1_nxt    = to_bcd({1'b0, sec_cnt});
        pend_cnt_nxt = 2'd2;
      end else begin
        out_byte_nxt = '0;
        out_has_nxt  = 1'b0;
        out_last_nxt = 1'b1;
      end
    end else if (out_pop && pend_cnt_r != 2'd0) begin
      // advance the read-out: shift the next time byte into the result
      out_valid_nxt = 1'b1;
      out_byte_nxt  = pend0_r;
      out_has_nxt   = 1'b1;
      out_last_nxt  = (pend_cnt_r == 2'd1);
      pend0_nxt     = pend1_r;
      pend_cnt_nxt  = pend_cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r       <= TPS_RESET;
      led_r       <= LED_RESET;
      out_valid_r <= 1'b0;
      pend_cnt_r  <= 2'd0;
    end else begin
      if (cfg_we) begin
        tps_r <= cfg_wdata;
      end
      led_r       <= led_nxt;
      out_valid_r <= out_valid_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

  // Payload: no reset needed
  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_led_r  <= out_led_nxt;
    out_has_r  <= out_has_nxt;
    out_last_r <= out_last_nxt;
    pend0_r    <= pend0_nxt;
    pend1_r    <= pend1_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_led_r, out_byte_r};
  assign out_tuser  = out_has_r;
  // Hour wrap needs no output; the cell already clears itself
  assign out_tlast  = out_last_r | (hr_carry & 1'b0);

endmodule

`default_nettype wire

// File: bench/testbench.sv
// Self-checking bench for the hh:mm:ss clock with serial commands and LED keys.
// Needs hms_pkg and the hms_clock_with_serial_commands RTL; a built-in predictor
// computes the expected result words.
module testbench;
  import hms_pkg::*;

  localparam int QUIET_LIMIT = 4000;  // cycles with no word moving on either side
  localparam int BACKLOG_MAX = 32;
  localparam int PRINT_MAX   = 50;

  // One input word: req_type travels in tuser, rx_byte in tdata.
  typedef struct packed {
    req_t       kind;
    logic [7:0] rx;
  } cmd_word_t;

  // One result word as the predictor expects it.
  typedef struct packed {
    logic       has_byte;
    logic [7:0] tx_byte;
    logic [7:0] led;
    logic       last;
  } clock_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] rx_byte
  logic [1:0]  in_tuser = '0;   // [1:0] req_type
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [7:0] tx_byte, [15:8] led_pattern
  logic [0:0]  out_tuser;       // [0] has_byte
  logic        out_tlast;
  logic        cfg_we = 1'b0;
  logic [7:0]  cfg_wdata = '0;  // [7:0] ticks_per_second

  hms_clock_with_serial_commands i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Commands waiting for the driver, and result words the clock still owes us.
  cmd_word_t   cmd_backlog[$];
  clock_word_t words_due[$];

  // Predictor copy of the clock: prescaler limit, time of day and LED register.
  logic [7:0] rate;
  logic [7:0] presc;
  logic [5:0] secs;
  logic [5:0] mins;
  logic [6:0] hrs;
  logic [7:0] leds;

  int  n_bad = 0;
  int  in_gap = 0;
  int  out_stall = 0;
  int  quiet = 0;
  bit  calm = 1'b0;  // when set, neither side idles

  task automatic report(input string msg);
    if (n_bad < PRINT_MAX) $display("mismatch: %s", msg);
    n_bad++;
  endtask

  function automatic logic [7:0] bcd_byte(input int unsigned v);
    return {4'(v / 10), 4'(v % 10)};
  endfunction

  // Mostly short idles, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic model_reset();
    rate  = TPS_RESET;
    presc = '0;
    secs  = '0;
    mins  = '0;
    hrs   = '0;
    leds  = LED_RESET;
  endtask

  // Apply one accepted command to the predictor and queue the words it owes.
  task automatic model_command(input cmd_word_t c);
    bit readout;
    readout = 1'b0;
    case (c.kind)
      REQ_TICK: begin
        // The prescaler is 8 bits wide: a limit of zero, or one below the
        // current count, is only met again after the count wraps.
        presc = presc + 8'd1;
        if (presc == rate) begin
          presc = '0;
          secs  = secs + 6'd1;
          if (secs == SEC_LIMIT) begin
            secs = '0;
            mins = mins + 6'd1;
            if (mins == MIN_LIMIT) begin
              mins = '0;
              hrs  = hrs + 7'd1;
              if (hrs == HR_LIMIT) hrs = '0;
            end
          end
        end
      end
      REQ_RX: begin
        if (c.rx[7:4] == CMD_LED_NIB) begin
          leds[3:0] = ~c.rx[3:0];
        end else if (c.rx == CMD_READ) begin
          readout = 1'b1;
        end
      end
      REQ_KEY_A: leds[LED_KEY_A_BIT] = ~leds[LED_KEY_A_BIT];
      REQ_KEY_B: leds[LED_KEY_B_BIT] = ~leds[LED_KEY_B_BIT];
    endcase
    if (readout) begin
      words_due.push_back('{1'b1, bcd_byte(hrs), leds, 1'b0});
      words_due.push_back('{1'b1, bcd_byte(mins), leds, 1'b0});
      words_due.push_back('{1'b1, bcd_byte(secs), leds, 1'b1});
    end else begin
      words_due.push_back('{1'b0, 8'h00, leds, 1'b1});
    end
  endtask

  // Driver: on acceptance, predict and maybe idle; when the slot is free,
  // either hold off or present the next command from the backlog.
  always @(posedge clk) begin : driver
    cmd_word_t nxt;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        model_command('{req_t'(in_tuser), in_tdata});
        if (!calm && $urandom_range(0, 2) == 0) in_gap = idle_len();
      end
      if (!in_tvalid || in_tready) begin
        if (!calm && in_gap > 0) begin
          in_gap--;
          in_tvalid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          nxt = cmd_backlog.pop_front();
          in_tuser  <= nxt.kind;
          in_tdata  <= nxt.rx;
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted word against the oldest one due, then
  // decide whether to stall the next cycle.
  always @(posedge clk) begin : monitor
    clock_word_t due;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (words_due.size() == 0) begin
          report($sformatf("word with none due: tdata %h tuser %b tlast %b",
                           out_tdata, out_tuser, out_tlast));
        end else begin
          due = words_due.pop_front();
          if (out_tuser[0] !== due.has_byte)
            report($sformatf("has_byte %b, want %b", out_tuser[0], due.has_byte));
          if (out_tdata[7:0] !== due.tx_byte)
            report($sformatf("tx_byte %h, want %h", out_tdata[7:0], due.tx_byte));
          if (out_tdata[15:8] !== due.led)
            report($sformatf("led_pattern %h, want %h", out_tdata[15:8], due.led));
          if (out_tlast !== due.last)
            report($sformatf("tlast %b, want %b", out_tlast, due.last));
        end
      end
      if (!calm && out_stall > 0) begin
        out_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) out_stall = idle_len();
      end
    end
  end

  // Watchdog: give up when no word moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Wait until the backlog is drained and every owed word has arrived.
  task automatic settle();
    while (cmd_backlog.size() > 0 || in_tvalid || words_due.size() > 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
    @(negedge clk);
  endtask

  // Write the prescaler limit while the clock is idle.
  task automatic set_rate(input logic [7:0] v);
    settle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    rate = v;
    @(negedge clk);
  endtask

  // Append one command, throttled so the backlog stays short.
  task automatic queue_cmd(input req_t k, input logic [7:0] b);
    while (cmd_backlog.size() >= BACKLOG_MAX) @(negedge clk);
    cmd_backlog.push_back('{k, b});
  endtask

  // Random mix: ticks, read commands, LED commands, stray bytes and keys.
  task automatic queue_random(input int n);
    int r;
    int s;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        queue_cmd(REQ_TICK, 8'($urandom));
      end else if (r < 80) begin
        s = $urandom_range(0, 9);
        if (s < 4) queue_cmd(REQ_RX, CMD_READ);
        else if (s < 7) queue_cmd(REQ_RX, {CMD_LED_NIB, 4'($urandom)});
        else queue_cmd(REQ_RX, 8'($urandom));
      end else if (r < 90) begin
        queue_cmd(REQ_KEY_A, 8'($urandom));
      end else begin
        queue_cmd(REQ_KEY_B, 8'($urandom));
      end
    end
  endtask

  initial begin : stimulus
    int n;
    model_reset();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: both keys twice, LED nibble extremes, stray bytes around
    // the command codes, and a readout at time zero.
    queue_cmd(REQ_KEY_A, 8'h00);
    queue_cmd(REQ_KEY_B, 8'hFF);
    queue_cmd(REQ_KEY_A, 8'h55);
    queue_cmd(REQ_KEY_B, 8'hAA);
    queue_cmd(REQ_RX, {CMD_LED_NIB, 4'h0});
    queue_cmd(REQ_RX, {CMD_LED_NIB, 4'hF});
    queue_cmd(REQ_RX, {CMD_LED_NIB, 4'h5});
    queue_cmd(REQ_RX, 8'h00);
    queue_cmd(REQ_RX, 8'hFF);
    queue_cmd(REQ_RX, 8'h9F);
    queue_cmd(REQ_RX, 8'hB1);
    queue_cmd(REQ_RX, 8'hBF);
    queue_cmd(REQ_RX, 8'h0B);
    queue_cmd(REQ_RX, CMD_READ);
    queue_cmd(REQ_RX, {CMD_LED_NIB, 4'hA});
    queue_cmd(REQ_KEY_A, 8'h0F);

    // One tick per second, back to back, across the first minute wrap with
    // readouts along the way. The prescaler is still at zero here since no
    // tick has been sent yet.
    set_rate(8'd1);
    calm = 1'b1;
    for (int i = 0; i < 64; i++) begin
      queue_cmd(REQ_TICK, 8'($urandom));
      if (i % 16 == 15) queue_cmd(REQ_RX, CMD_READ);
    end
    settle();
    calm = 1'b0;

    set_rate(TPS_RESET);
    queue_random(40);

    // A limit of zero sits below the running count: the prescaler must wrap
    // through 255 before the next second, then fire every 256 ticks.
    set_rate(8'd0);
    n = 258 - int'(presc);
    for (int i = 0; i < n; i++) begin
      queue_cmd(REQ_TICK, 8'($urandom));
      if (i % 64 == 63) queue_cmd(REQ_RX, CMD_READ);
    end
    queue_cmd(REQ_RX, CMD_READ);

    // One stretch with no idling on either side.
    set_rate(8'd3);
    calm = 1'b1;
    queue_random(25);
    settle();
    calm = 1'b0;

    set_rate(8'($urandom_range(2, 254)));
    queue_random(20);

    settle();
    repeat (8) @(posedge clk);
    if (n_bad == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/hms_pkg.sv
hdl/hms_cnt_cell.sv
hdl/hms_clock_with_serial_commands.sv
bench/testbench.sv
